@@ rtl/core/qse_pkg.sv @@
// qse_pkg: shared types for the quicksort engine
// command and status bundles between qse_ctrl and qse_datapath
// no dependencies
`default_nettype none

package qse_pkg;

	localparam int DATA_W = 32;

	typedef struct packed {
		logic load_wr;
		logic push_root;
		logic emit_clr;
		logic st_pop;
		logic take_range;
		logic rd_pivot;
		logic take_pivot;
		logic rd_left;
		logic take_left;
		logic inc_left;
		logic rd_right;
		logic take_right;
		logic dec_right;
		logic wr_left;
		logic wr_right;
		logic push_low;
		logic push_high;
		logic rd_emit;
		logic take_out;
		logic out_clr;
		logic emit_inc;
	} qse_cmd_t;

	typedef struct packed {
		logic load_done;
		logic stack_empty;
		logic range_ok;
		logic left_go;
		logic right_go;
		logic cross_ok;
		logic emit_last;
	} qse_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/qse_ctrl.sv @@
// qse_ctrl: sequencer for load, partition sort and emit
// drives qse_datapath through qse_pkg::qse_cmd_t, reads qse_pkg::qse_sts_t
// depends on qse_pkg
`default_nettype none

module qse_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_stall,
	input  wire qse_pkg::qse_sts_t sts,
	output qse_pkg::qse_cmd_t      cmd,
	output logic                   in_stall
);

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_INIT,
		ST_POP,
		ST_RANGE,
		ST_PIVOT,
		ST_LRD,
		ST_LCMP,
		ST_RRD,
		ST_RCMP,
		ST_CHECK,
		ST_SWA,
		ST_SWB,
		ST_LOOP,
		ST_PUSHL,
		ST_PUSHH,
		ST_ERD,
		ST_ELD,
		ST_EHOLD
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != ST_LOAD);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOAD:  cmd.load_wr = in_valid;
			ST_INIT: begin
				cmd.push_root = 1'b1;
				cmd.emit_clr  = 1'b1;
			end
			ST_POP:   cmd.st_pop = !sts.stack_empty;
			ST_RANGE: begin
				cmd.take_range = sts.range_ok;
				cmd.rd_pivot   = sts.range_ok;
			end
			ST_PIVOT: cmd.take_pivot = 1'b1;
			ST_LRD:   cmd.rd_left = 1'b1;
			ST_LCMP: begin
				cmd.take_left = 1'b1;
				cmd.inc_left  = sts.left_go;
			end
			ST_RRD:   cmd.rd_right = 1'b1;
			ST_RCMP: begin
				cmd.take_right = 1'b1;
				cmd.dec_right  = sts.right_go;
			end
			ST_SWA:   cmd.wr_left = 1'b1;
			ST_SWB: begin
				cmd.wr_right  = 1'b1;
				cmd.inc_left  = 1'b1;
				cmd.dec_right = 1'b1;
			end
			ST_PUSHL: cmd.push_low = 1'b1;
			ST_PUSHH: cmd.push_high = 1'b1;
			ST_ERD:   cmd.rd_emit = 1'b1;
			ST_ELD:   cmd.take_out = 1'b1;
			ST_EHOLD: begin
				cmd.out_clr  = !out_stall;
				cmd.emit_inc = !out_stall && !sts.emit_last;
			end
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_valid && sts.load_done) state_q <= ST_INIT;
				end
				ST_INIT:  state_q <= ST_POP;
				ST_POP:   state_q <= sts.stack_empty ? ST_ERD : ST_RANGE;
				ST_RANGE: state_q <= sts.range_ok ? ST_PIVOT : ST_POP;
				ST_PIVOT: state_q <= ST_LRD;
				ST_LRD:   state_q <= ST_LCMP;
				ST_LCMP:  state_q <= sts.left_go ? ST_LRD : ST_RRD;
				ST_RRD:   state_q <= ST_RCMP;
				ST_RCMP:  state_q <= sts.right_go ? ST_RRD : ST_CHECK;
				ST_CHECK: state_q <= sts.cross_ok ? ST_SWA : ST_PUSHL;
				ST_SWA:   state_q <= ST_SWB;
				ST_SWB:   state_q <= ST_LOOP;
				ST_LOOP:  state_q <= sts.cross_ok ? ST_LRD : ST_PUSHL;
				ST_PUSHL: state_q <= ST_PUSHH;
				ST_PUSHH: state_q <= ST_POP;
				ST_ERD:   state_q <= ST_ELD;
				ST_ELD:   state_q <= ST_EHOLD;
				ST_EHOLD: begin
					if (!out_stall) state_q <= sts.emit_last ? ST_LOAD : ST_ERD;
				end
				default:  state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/qse_datapath.sv @@
// qse_datapath: element store, range stack, partition indices and output register
// acts on qse_pkg::qse_cmd_t from qse_ctrl, returns qse_pkg::qse_sts_t
// depends on qse_pkg
`default_nettype none

module qse_datapath #(
	parameter int ITEMS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire qse_pkg::qse_cmd_t             cmd,
	input  wire logic signed [qse_pkg::DATA_W-1:0] value,
	output qse_pkg::qse_sts_t                  sts,
	output logic signed [qse_pkg::DATA_W-1:0]  sorted_value,
	output logic                               last,
	output logic                               out_valid
);

	localparam int IW = $clog2(ITEMS);
	localparam int XW = IW + 2;
	localparam int SW = $clog2(ITEMS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ITEMS - 1);
	localparam logic [SW-1:0] STK_FULL = SW'(ITEMS);

	logic signed [qse_pkg::DATA_W-1:0] mem [ITEMS];
	logic [2*IW-1:0] stk [ITEMS];

	logic signed [qse_pkg::DATA_W-1:0] rd_q;
	logic signed [qse_pkg::DATA_W-1:0] pivot_q;
	logic signed [qse_pkg::DATA_W-1:0] lval_q;
	logic signed [qse_pkg::DATA_W-1:0] rval_q;
	logic signed [qse_pkg::DATA_W-1:0] out_data_q;
	logic [2*IW-1:0] stk_rd_q;
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] ecnt_q;
	logic [SW-1:0] sp_q;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic signed [XW-1:0] li_q;
	logic signed [XW-1:0] ri_q;
	logic last_q;
	logic out_valid_q;

	logic [IW-1:0] stk_lo;
	logic [IW-1:0] stk_hi;
	logic [IW:0] span;
	logic [IW:0] mid;
	logic signed [XW-1:0] lo_ext;
	logic signed [XW-1:0] hi_ext;
	logic [SW-1:0] sp_m1;
	logic rd_en;
	logic [IW-1:0] rd_addr;
	logic wr_en;
	logic [IW-1:0] wr_addr;
	logic signed [qse_pkg::DATA_W-1:0] wr_data;
	logic low_ok;
	logic high_ok;
	logic st_we;
	logic [2*IW-1:0] st_wd;

	assign stk_lo = stk_rd_q[2*IW-1:IW];
	assign stk_hi = stk_rd_q[IW-1:0];
	assign span   = {1'b0, stk_hi} - {1'b0, stk_lo} + (IW+1)'(1);
	assign mid    = {1'b0, stk_lo} + (span >> 1);
	assign lo_ext = $signed({2'b00, lo_q});
	assign hi_ext = $signed({2'b00, hi_q});
	assign sp_m1  = sp_q - SW'(1);
	assign low_ok  = ri_q > lo_ext;
	assign high_ok = li_q < hi_ext;

	always_comb begin
		rd_en   = 1'b1;
		rd_addr = ecnt_q;
		if (cmd.rd_pivot) begin
			rd_addr = mid[IW-1:0];
		end else if (cmd.rd_left) begin
			rd_addr = li_q[IW-1:0];
		end else if (cmd.rd_right) begin
			rd_addr = ri_q[IW-1:0];
		end else if (!cmd.rd_emit) begin
			rd_en = 1'b0;
		end
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = cnt_q;
		wr_data = value;
		if (cmd.wr_left) begin
			wr_addr = li_q[IW-1:0];
			wr_data = rval_q;
		end else if (cmd.wr_right) begin
			wr_addr = ri_q[IW-1:0];
			wr_data = lval_q;
		end else if (!cmd.load_wr) begin
			wr_en = 1'b0;
		end
	end

	always_comb begin
		st_wd = {IW'(0), LAST_IDX};
		if (cmd.push_low) begin
			st_wd = {lo_q, ri_q[IW-1:0]};
		end else if (cmd.push_high) begin
			st_wd = {li_q[IW-1:0], hi_q};
		end
		st_we = (cmd.push_root || (cmd.push_low && low_ok) || (cmd.push_high && high_ok))
			&& (sp_q < STK_FULL);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (st_we) stk[sp_q[IW-1:0]] <= st_wd;
		if (cmd.st_pop) stk_rd_q <= stk[sp_m1[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.take_range) begin
			lo_q <= stk_lo;
			hi_q <= stk_hi;
		end
		if (cmd.take_pivot) pivot_q <= rd_q;
		if (cmd.take_left) lval_q <= rd_q;
		if (cmd.take_right) rval_q <= rd_q;
		if (cmd.take_out) begin
			out_data_q <= rd_q;
			last_q     <= (ecnt_q == LAST_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ecnt_q      <= '0;
			sp_q        <= '0;
			li_q        <= '0;
			ri_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_wr) cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IW'(1);
			if (cmd.emit_clr) begin
				ecnt_q <= '0;
			end else if (cmd.emit_inc) begin
				ecnt_q <= ecnt_q + IW'(1);
			end
			if (st_we) begin
				sp_q <= sp_q + SW'(1);
			end else if (cmd.st_pop) begin
				sp_q <= sp_m1;
			end
			if (cmd.take_range) begin
				li_q <= $signed({2'b00, stk_lo});
				ri_q <= $signed({2'b00, stk_hi});
			end else begin
				if (cmd.inc_left) li_q <= li_q + XW'(1);
				if (cmd.dec_right) ri_q <= ri_q - XW'(1);
			end
			if (cmd.take_out) begin
				out_valid_q <= 1'b1;
			end else if (cmd.out_clr) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.load_done   = (cnt_q == LAST_IDX);
		sts.stack_empty = (sp_q == '0);
		sts.range_ok    = (stk_lo < stk_hi);
		sts.left_go     = (li_q < hi_ext) && (rd_q < pivot_q);
		sts.right_go    = (ri_q > lo_ext) && (rd_q > pivot_q);
		sts.cross_ok    = (li_q <= ri_q);
		sts.emit_last   = (ecnt_q == LAST_IDX);
	end

	assign sorted_value = out_data_q;
	assign last         = last_q;
	assign out_valid    = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/quicksort_engine_unit.sv @@
// quicksort_engine_unit: loads ITEMS signed values, sorts them, emits them ascending
// top level joining qse_ctrl and qse_datapath
// depends on qse_pkg, qse_ctrl, qse_datapath
//
//  channel  handshake            payload
//  in       in_valid / in_stall  value[31:0] signed
//  out      out_valid / out_stall sorted_value[31:0] signed, last
//
// loading accepts one request per cycle; the last request starts the sort
// the sort runs in place on the element store: a scan step reads an element, then
// compares it with the pivot; a swap writes the left slot, then the right slot
// emitting holds each result in the output register while out_stall is high
// in_stall is high from the last load until the final result is taken
// reset clears the sequencer, counters and out_valid; the store needs no clearing
`default_nettype none

module quicksort_engine_unit #(
	parameter int ITEMS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [qse_pkg::DATA_W-1:0] value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [qse_pkg::DATA_W-1:0]      sorted_value,
	output logic                                   last
);

	qse_pkg::qse_cmd_t cmd;
	qse_pkg::qse_sts_t sts;

	qse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	qse_datapath #(
		.ITEMS (ITEMS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.sts          (sts),
		.sorted_value (sorted_value),
		.last         (last),
		.out_valid    (out_valid)
	);

endmodule

`default_nettype wire
